>>> hdl/wpas_pkg.sv
// Package for the waypoint arrival sequencer: widths, CORDIC types and the
// arctangent table. No dependencies.
`default_nettype none
package wpas_pkg;
    localparam int MAX_WAYPOINTS_DEF = 8;
    localparam int CORDIC_STEPS_DEF  = 14;

    localparam int POS_W  = 20;
    localparam int QUAT_W = 16;
    localparam int YAW_W  = 16;
    localparam int XW     = 36;
    localparam int ANG_W  = 24;
    localparam int ENTRY_W = 3*POS_W + YAW_W + 4*QUAT_W;

    localparam logic signed [ANG_W-1:0] HALF_PI_A = 24'sd1647099;
    localparam logic signed [XW-1:0]    ONE_Q28   = 36'sd268435456;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_POSE  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [2:0] CFG_DIST_TOL  = 3'd0;
    localparam logic [2:0] CFG_YAW_TOL   = 3'd1;
    localparam logic [2:0] CFG_DWELL     = 3'd2;
    localparam logic [2:0] CFG_WP_COUNT  = 3'd3;
    localparam logic [2:0] CFG_LAND      = 3'd4;

    typedef struct packed {
        logic                    zero;
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ANG_W-1:0] a;
    } cordic_t;

    function automatic logic signed [ANG_W-1:0] atan_val(input int k);
        logic signed [ANG_W-1:0] v;
        case (k)
            0:  v = 24'sd823550;
            1:  v = 24'sd486170;
            2:  v = 24'sd256879;
            3:  v = 24'sd130396;
            4:  v = 24'sd65451;
            5:  v = 24'sd32757;
            6:  v = 24'sd16383;
            7:  v = 24'sd8192;
            8:  v = 24'sd4096;
            9:  v = 24'sd2048;
            10: v = 24'sd1024;
            11: v = 24'sd512;
            12: v = 24'sd256;
            13: v = 24'sd128;
            14: v = 24'sd64;
            15: v = 24'sd32;
            16: v = 24'sd16;
            17: v = 24'sd8;
            18: v = 24'sd4;
            19: v = 24'sd2;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> hdl/wpas_intf.sv
// Request, result and configuration channel interfaces.
// Depends on wpas_pkg.
`default_nettype none
interface wpas_item_if
    import wpas_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [2:0]               entry_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    modport source (output valid, req_type, entry_index, pos_x, pos_y, pos_z,
                    quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, req_type, entry_index, pos_x, pos_y, pos_z,
                  quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface wpas_result_if
    import wpas_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  sp_x;
    logic signed [POS_W-1:0]  sp_y;
    logic signed [POS_W-1:0]  sp_z;
    logic signed [QUAT_W-1:0] sp_qw;
    logic signed [QUAT_W-1:0] sp_qx;
    logic signed [QUAT_W-1:0] sp_qy;
    logic signed [QUAT_W-1:0] sp_qz;
    logic [3:0]               target_index;
    logic                     in_tolerance;
    logic                     mission_done;
    logic                     disarm_request;
    modport source (output valid, sp_x, sp_y, sp_z, sp_qw, sp_qx, sp_qy, sp_qz,
                    target_index, in_tolerance, mission_done, disarm_request,
                    input ready);
    modport sink (input valid, sp_x, sp_y, sp_z, sp_qw, sp_qx, sp_qy, sp_qz,
                  target_index, in_tolerance, mission_done, disarm_request,
                  output ready);
endinterface

interface wpas_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [39:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/wpas_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module wpas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> hdl/wpas_cordic_cell.sv
// One CORDIC vectoring step with its output register.
// Depends on wpas_pkg.
`default_nettype none
module wpas_cordic_cell
    import wpas_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    vld,
    input  wire cordic_t din,
    output logic         vld_out,
    output cordic_t      dout
);
    logic    vld_reg;
    cordic_t data_reg, data_next;

    always_comb
    begin
        data_next      = din;
        if (din.y >= 0)
        begin
            data_next.x = din.x + (din.y >>> STEP);
            data_next.y = din.y - (din.x >>> STEP);
            data_next.a = din.a + atan_val(STEP);
        end
        else
        begin
            data_next.x = din.x - (din.y >>> STEP);
            data_next.y = din.y + (din.x >>> STEP);
            data_next.a = din.a - atan_val(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign vld_out = vld_reg;
    assign dout    = data_reg;
endmodule
`default_nettype wire

>>> hdl/wpas_cordic_chain.sv
// Yaw atan2 chain: vector setup, quadrant pre-rotation, then a row of cells.
// Depends on wpas_pkg and wpas_cordic_cell.
`default_nettype none
module wpas_cordic_chain
    import wpas_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     vld,
    input  wire logic signed [31:0]       p_xy,
    input  wire logic signed [31:0]       p_wz,
    input  wire logic signed [31:0]       p_yy,
    input  wire logic signed [31:0]       p_zz,
    output logic                          vld_out,
    output logic                          zero_out,
    output logic signed [ANG_W-1:0]       ang_out
);
    logic signed [XW-1:0] t1, t0;
    cordic_t              head_next, head_reg;
    logic                 head_vld_reg;
    logic                 vld_c [CORDIC_STEPS+1];
    cordic_t              data_c [CORDIC_STEPS+1];

    always_comb
    begin
        t1 = (XW'(p_xy) + XW'(p_wz)) <<< 1;
        t0 = ONE_Q28 - ((XW'(p_yy) + XW'(p_zz)) <<< 1);
        head_next.zero = (t0 == '0) && (t1 == '0);
        head_next.x    = t0;
        head_next.y    = t1;
        head_next.a    = '0;
        if (t0 < 0)
        begin
            if (t1 >= 0)
            begin
                head_next.x = t1;
                head_next.y = -t0;
                head_next.a = HALF_PI_A;
            end
            else
            begin
                head_next.x = -t1;
                head_next.y = t0;
                head_next.a = -HALF_PI_A;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    assign vld_c[0]  = head_vld_reg;
    assign data_c[0] = head_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        wpas_cordic_cell #(.STEP(k)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld     (vld_c[k]),
            .din     (data_c[k]),
            .vld_out (vld_c[k+1]),
            .dout    (data_c[k+1])
        );
    end

    assign vld_out  = vld_c[CORDIC_STEPS];
    assign zero_out = data_c[CORDIC_STEPS].zero;
    assign ang_out  = data_c[CORDIC_STEPS].a;
endmodule
`default_nettype wire

>>> hdl/waypoint_arrival_sequencer_unit.sv
// Waypoint arrival sequencer top level: request latch, table RAM, distance
// pipeline, CORDIC chain, mission state and result register.
// Depends on wpas_pkg, wpas_intf, wpas_ram and wpas_cordic_chain.
//
// channel | dir | payload
// item    | in  | req_type, entry_index, pos_x/y/z, quat_w/x/y/z
// result  | out | sp_x/y/z, sp_qw/qx/qy/qz, target_index, flags
// cfg     | in  | index, data (always ready)
//
// One request at a time; an advance that moves to a later table entry fetches
// it from the table before the result register is loaded.
// A request is taken only while idle; a finished result waits for the
// result slot. Reset clears control state; table contents undefined.
`default_nettype none
module waypoint_arrival_sequencer_unit
    import wpas_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wpas_item_if.sink     item,
    wpas_result_if.source result,
    wpas_cfg_if.sink      cfg
);
    localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [39:0] dist_tol_reg;
    logic [14:0] yaw_tol_reg;
    logic [15:0] dwell_limit_reg;
    logic [3:0]  wp_count_reg;
    logic [18:0] land_reg;

    logic [1:0]               req_reg;
    logic [2:0]               ent_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [QUAT_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    logic               prod_vld_reg;
    logic signed [31:0] p_xy_reg, p_wz_reg, p_yy_reg, p_zz_reg;

    logic                   ch_vld, ch_zero;
    logic signed [ANG_W-1:0] ch_ang;
    logic signed [ANG_W:0]   ang_rnd;
    logic signed [YAW_W-1:0] yaw_reg;

    logic                re, we;
    logic [IW-1:0]       raddr, waddr;
    logic [ENTRY_W-1:0]  rdata, wdata;

    logic signed [POS_W-1:0]  t_x, t_y, t_z;
    logic signed [YAW_W-1:0]  t_yaw;

    logic signed [POS_W:0]   dx_reg, dy_reg, dz_reg;
    logic [41:0]             sx_reg, sy_reg, sz_reg;
    logic [41:0]             dsq_reg;

    logic [15:0] dwell_reg, dwell_next, dwell_tmp;
    logic        pend_reg, pend_next;
    logic [3:0]  wi_reg, wi_next, wi_inc, eff;
    logic        active_reg, active_next;
    logic        fin_reg, fin_next;
    logic        intol_reg, intol_next, disarm_reg, disarm_next;

    logic signed [POS_W-1:0]  spx_reg, spy_reg, spz_reg;
    logic signed [QUAT_W-1:0] spqw_reg, spqx_reg, spqy_reg, spqz_reg;
    logic                     sp_load_pose, sp_load_tbl;

    logic signed [YAW_W:0]   dyaw;
    logic [YAW_W:0]          dyaw_abs;
    logic                    intol;
    logic                    advance;

    logic                     out_vld_reg;
    logic signed [POS_W-1:0]  o_x_reg, o_y_reg, o_z_reg;
    logic signed [QUAT_W-1:0] o_qw_reg, o_qx_reg, o_qy_reg, o_qz_reg;
    logic [3:0]               o_idx_reg;
    logic                     o_tol_reg, o_done_reg, o_dis_reg;
    logic                     out_free, item_acc;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_vld_reg || result.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_tol_reg    <= 40'd167772;
            yaw_tol_reg     <= 15'd696;
            dwell_limit_reg <= 16'd150;
            wp_count_reg    <= 4'd7;
            land_reg        <= 19'd1024;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DIST_TOL: dist_tol_reg    <= cfg.data;
                CFG_YAW_TOL:  yaw_tol_reg     <= cfg.data[14:0];
                CFG_DWELL:    dwell_limit_reg <= cfg.data[15:0];
                CFG_WP_COUNT: wp_count_reg    <= cfg.data[3:0];
                CFG_LAND:     land_reg        <= cfg.data[18:0];
                default:      ;
            endcase
        end
    end

    // request latch and quaternion products
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            req_reg  <= item.req_type;
            ent_reg  <= item.entry_index;
            px_reg   <= item.pos_x;
            py_reg   <= item.pos_y;
            pz_reg   <= item.pos_z;
            qw_reg   <= item.quat_w;
            qx_reg   <= item.quat_x;
            qy_reg   <= item.quat_y;
            qz_reg   <= item.quat_z;
            p_xy_reg <= 32'(item.quat_x * item.quat_y);
            p_wz_reg <= 32'(item.quat_w * item.quat_z);
            p_yy_reg <= 32'(item.quat_y * item.quat_y);
            p_zz_reg <= 32'(item.quat_z * item.quat_z);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= item_acc;
        end
    end

    wpas_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld      (prod_vld_reg),
        .p_xy     (p_xy_reg),
        .p_wz     (p_wz_reg),
        .p_yy     (p_yy_reg),
        .p_zz     (p_zz_reg),
        .vld_out  (ch_vld),
        .zero_out (ch_zero),
        .ang_out  (ch_ang)
    );

    assign ang_rnd = (ANG_W+1)'(ch_ang) + (ANG_W+1)'(128);

    always_ff @(posedge clk)
    begin
        if (ch_vld)
        begin
            yaw_reg <= ch_zero ? '0 : YAW_W'(ang_rnd >>> 8);
        end
    end

    // table RAM
    always_comb
    begin
        eff = wp_count_reg;
        if (wp_count_reg == 4'd0)
        begin
            eff = 4'd1;
        end
        else if (int'(wp_count_reg) > MAX_WAYPOINTS)
        begin
            eff = 4'(MAX_WAYPOINTS);
        end
        wi_inc = wi_reg + 4'd1;
        re     = 1'b0;
        raddr  = (int'(wi_reg) >= MAX_WAYPOINTS) ? IW'(MAX_WAYPOINTS-1) : IW'(wi_reg);
        if (item_acc)
        begin
            re = 1'b1;
        end
        else if (state_reg == ST_EVAL && advance && wi_inc < eff)
        begin
            re    = 1'b1;
            raddr = (int'(wi_inc) >= MAX_WAYPOINTS) ? IW'(MAX_WAYPOINTS-1) : IW'(wi_inc);
        end
    end

    assign we    = (state_reg == ST_EVAL) && (req_reg == REQ_LOAD) &&
                   (int'(ent_reg) < MAX_WAYPOINTS);
    assign waddr = IW'(ent_reg);
    assign wdata = {px_reg, py_reg, pz_reg, yaw_reg, qw_reg, qx_reg, qy_reg, qz_reg};

    wpas_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WAYPOINTS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign t_x   = rdata[ENTRY_W-1 -: POS_W];
    assign t_y   = rdata[ENTRY_W-1-POS_W -: POS_W];
    assign t_z   = rdata[ENTRY_W-1-2*POS_W -: POS_W];
    assign t_yaw = rdata[4*QUAT_W +: YAW_W];

    // distance pipeline; settles long before the chain finishes
    always_ff @(posedge clk)
    begin
        dx_reg  <= (POS_W+1)'(px_reg) - (POS_W+1)'(t_x);
        dy_reg  <= (POS_W+1)'(py_reg) - (POS_W+1)'(t_y);
        dz_reg  <= (POS_W+1)'(pz_reg) - (POS_W+1)'(t_z);
        sx_reg  <= 42'(dx_reg * dx_reg);
        sy_reg  <= 42'(dy_reg * dy_reg);
        sz_reg  <= 42'(dz_reg * dz_reg);
        dsq_reg <= sx_reg + sy_reg + sz_reg;
    end

    // mission decision
    always_comb
    begin
        dyaw         = (YAW_W+1)'(yaw_reg) - (YAW_W+1)'(t_yaw);
        dyaw_abs     = dyaw[YAW_W] ? (YAW_W+1)'(-dyaw) : (YAW_W+1)'(dyaw);
        intol        = (dsq_reg < {2'b00, dist_tol_reg}) &&
                       (dyaw_abs < {2'b00, yaw_tol_reg});
        dwell_next   = dwell_reg;
        pend_next    = pend_reg;
        wi_next      = wi_reg;
        active_next  = active_reg;
        fin_next     = fin_reg;
        intol_next   = 1'b0;
        disarm_next  = 1'b0;
        sp_load_pose = 1'b0;
        sp_load_tbl  = 1'b0;
        advance      = 1'b0;
        dwell_tmp    = dwell_reg;
        if (state_reg == ST_EVAL)
        begin
            case (req_reg)
                REQ_START: active_next = 1'b1;
                REQ_POSE:
                begin
                    if (!fin_reg)
                    begin
                        intol_next = intol;
                        if (intol)
                        begin
                            dwell_tmp = (dwell_reg == 16'hFFFF) ? dwell_reg
                                                                : dwell_reg + 16'd1;
                        end
                        else
                        begin
                            dwell_tmp = '0;
                        end
                        dwell_next = dwell_tmp;
                        if (dwell_tmp > dwell_limit_reg)
                        begin
                            dwell_next = '0;
                            pend_next  = 1'b1;
                        end
                        advance = active_reg && pend_next;
                        if (advance)
                        begin
                            pend_next = 1'b0;
                            wi_next   = wi_inc;
                            if (wi_inc < eff)
                            begin
                                sp_load_tbl = 1'b1;
                            end
                            else
                            begin
                                active_next  = 1'b0;
                                fin_next     = 1'b1;
                                sp_load_pose = 1'b1;
                            end
                        end
                    end
                    disarm_next = fin_next &&
                                  ((POS_W+1)'(pz_reg) <= $signed({2'b00, land_reg}));
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (item_acc) state_next = ST_RUN;
            ST_RUN:   if (ch_vld) state_next = ST_EVAL;
            ST_EVAL:  state_next = sp_load_tbl ? ST_FETCH : ST_DONE;
            ST_FETCH: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dwell_reg  <= '0;
            pend_reg   <= 1'b0;
            wi_reg     <= '0;
            active_reg <= 1'b0;
            fin_reg    <= 1'b0;
            intol_reg  <= 1'b0;
            disarm_reg <= 1'b0;
            spx_reg    <= '0;
            spy_reg    <= '0;
            spz_reg    <= '0;
            spqw_reg   <= '0;
            spqx_reg   <= '0;
            spqy_reg   <= '0;
            spqz_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dwell_reg  <= dwell_next;
            pend_reg   <= pend_next;
            wi_reg     <= wi_next;
            active_reg <= active_next;
            fin_reg    <= fin_next;
            if (state_reg == ST_EVAL)
            begin
                intol_reg  <= intol_next;
                disarm_reg <= disarm_next;
            end
            if (sp_load_pose)
            begin
                spx_reg  <= px_reg;
                spy_reg  <= py_reg;
                spz_reg  <= '0;
                spqw_reg <= qw_reg;
                spqx_reg <= qx_reg;
                spqy_reg <= qy_reg;
                spqz_reg <= qz_reg;
            end
            else if (state_reg == ST_FETCH)
            begin
                spx_reg  <= t_x;
                spy_reg  <= t_y;
                spz_reg  <= t_z;
                spqw_reg <= rdata[3*QUAT_W +: QUAT_W];
                spqx_reg <= rdata[2*QUAT_W +: QUAT_W];
                spqy_reg <= rdata[QUAT_W +: QUAT_W];
                spqz_reg <= rdata[0 +: QUAT_W];
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            o_x_reg    <= spx_reg;
            o_y_reg    <= spy_reg;
            o_z_reg    <= spz_reg;
            o_qw_reg   <= spqw_reg;
            o_qx_reg   <= spqx_reg;
            o_qy_reg   <= spqy_reg;
            o_qz_reg   <= spqz_reg;
            o_idx_reg  <= wi_reg;
            o_tol_reg  <= intol_reg;
            o_done_reg <= fin_reg;
            o_dis_reg  <= disarm_reg;
        end
    end

    assign result.valid          = out_vld_reg;
    assign result.sp_x           = o_x_reg;
    assign result.sp_y           = o_y_reg;
    assign result.sp_z           = o_z_reg;
    assign result.sp_qw          = o_qw_reg;
    assign result.sp_qx          = o_qx_reg;
    assign result.sp_qy          = o_qy_reg;
    assign result.sp_qz          = o_qz_reg;
    assign result.target_index   = o_idx_reg;
    assign result.in_tolerance   = o_tol_reg;
    assign result.mission_done   = o_done_reg;
    assign result.disarm_request = o_dis_reg;

`ifndef NO_ASSERTIONS
    a_chain_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ch_vld |-> state_reg == ST_RUN)
        else $error("chain result outside run state");
    a_fetch_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> $past(state_reg) == ST_EVAL)
        else $error("fetch without evaluation");
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> state_reg == ST_RUN)
        else $error("request taken but not started");
    a_disarm_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.disarm_request |-> result.mission_done)
        else $error("disarm before mission done");
`endif
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for waypoint_arrival_sequencer_unit: directed and random requests,
// a scoreboard class that predicts each result and checks it field by field.
// Depends on wpas_pkg, wpas_intf and the unit's RTL.
`default_nettype none
module tb_top;
    import wpas_pkg::*;

    typedef struct {
        logic [1:0]               kind;
        logic [2:0]               entry;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic signed [QUAT_W-1:0] qw;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
    } request_t;

    typedef struct {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic signed [QUAT_W-1:0] qw;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic [3:0]               idx;
        logic                     tol;
        logic                     done;
        logic                     disarm;
    } setpoint_t;

    localparam int NWP = MAX_WAYPOINTS_DEF;
    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    class mission_scoreboard;
        longint wp_x[NWP], wp_y[NWP], wp_z[NWP], wp_yaw[NWP];
        longint wp_q[NWP][4];
        longint sp_p[3], sp_q[4];
        int unsigned dwell;
        bit pending, active, finished;
        int unsigned target;
        longint unsigned dist_tol, yaw_tol, dwell_limit, wp_count, land;
        setpoint_t expected_q[$];
        int mismatches;

        function new();
            dist_tol = 167772;
            yaw_tol = 696;
            dwell_limit = 150;
            wp_count = 7;
            land = 1024;
            mismatches = 0;
            dwell = 0;
            pending = 0;
            active = 0;
            finished = 0;
            target = 0;
            foreach (sp_p[i]) sp_p[i] = 0;
            foreach (sp_q[i]) sp_q[i] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [39:0] data);
            case (idx)
                CFG_DIST_TOL: dist_tol = 64'(data);
                CFG_YAW_TOL:  yaw_tol = 64'(data[14:0]);
                CFG_DWELL:    dwell_limit = 64'(data[15:0]);
                CFG_WP_COUNT: wp_count = 64'(data[3:0]);
                CFG_LAND:     land = 64'(data[18:0]);
                default: ;
            endcase
        endfunction

        function longint heading(longint w, longint x, longint y, longint z);
            longint angle_step[20] = '{823550, 486170, 256879, 130396, 65451, 32757,
                16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
            longint t1, t0, a, nx, ny, dx, dy;
            t1 = 2 * (x * y + w * z);
            t0 = (longint'(1) << 28) - 2 * (y * y + z * z);
            a = 0;
            if (t0 == 0 && t1 == 0)
                return 0;
            if (t0 < 0)
            begin
                if (t1 >= 0)
                begin
                    nx = t1; ny = -t0; a = longint'(HALF_PI_A);
                end
                else
                begin
                    nx = -t1; ny = t0; a = -longint'(HALF_PI_A);
                end
                t0 = nx;
                t1 = ny;
            end
            for (int k = 0; k < STEPS; k++)
            begin
                dx = t1 >>> k;
                dy = t0 >>> k;
                if (t1 >= 0)
                begin
                    t0 += dx; t1 -= dy; a += angle_step[k];
                end
                else
                begin
                    t0 -= dx; t1 += dy; a -= angle_step[k];
                end
            end
            return (a + 128) >>> 8;
        endfunction

        function int unsigned live_count();
            if (wp_count == 0) return 1;
            if (wp_count > NWP) return NWP;
            return 32'(wp_count);
        endfunction

        function void note_request(request_t r);
            longint p[3], q[4], dx, dy, dz, dyaw;
            longint unsigned dsq;
            int unsigned t;
            bit tol, disarm;
            setpoint_t e;
            p[0] = r.px; p[1] = r.py; p[2] = r.pz;
            q[0] = r.qw; q[1] = r.qx; q[2] = r.qy; q[3] = r.qz;
            tol = 0;
            disarm = 0;
            if (r.kind == REQ_LOAD)
            begin
                wp_x[r.entry] = p[0];
                wp_y[r.entry] = p[1];
                wp_z[r.entry] = p[2];
                wp_yaw[r.entry] = heading(q[0], q[1], q[2], q[3]);
                for (int j = 0; j < 4; j++) wp_q[r.entry][j] = q[j];
            end
            else if (r.kind == REQ_START)
                active = 1;
            else if (r.kind == REQ_POSE)
            begin
                if (!finished)
                begin
                    t = target < NWP ? target : NWP - 1;
                    dx = p[0] - wp_x[t];
                    dy = p[1] - wp_y[t];
                    dz = p[2] - wp_z[t];
                    dsq = dx * dx + dy * dy + dz * dz;
                    dyaw = heading(q[0], q[1], q[2], q[3]) - wp_yaw[t];
                    if (dyaw < 0) dyaw = -dyaw;
                    tol = dsq < dist_tol && dyaw < yaw_tol;
                    if (tol)
                    begin
                        if (dwell < 65535) dwell++;
                    end
                    else
                        dwell = 0;
                    if (dwell > dwell_limit)
                    begin
                        dwell = 0;
                        pending = 1;
                    end
                    if (active && pending)
                    begin
                        pending = 0;
                        target++;
                        if (target < live_count())
                        begin
                            t = target < NWP ? target : NWP - 1;
                            sp_p[0] = wp_x[t]; sp_p[1] = wp_y[t]; sp_p[2] = wp_z[t];
                            for (int j = 0; j < 4; j++) sp_q[j] = wp_q[t][j];
                        end
                        else
                        begin
                            active = 0;
                            finished = 1;
                            sp_p[0] = p[0]; sp_p[1] = p[1]; sp_p[2] = 0;
                            for (int j = 0; j < 4; j++) sp_q[j] = q[j];
                        end
                    end
                end
                disarm = finished && p[2] <= longint'(land);
            end
            e.x = POS_W'(sp_p[0]); e.y = POS_W'(sp_p[1]); e.z = POS_W'(sp_p[2]);
            e.qw = QUAT_W'(sp_q[0]); e.qx = QUAT_W'(sp_q[1]);
            e.qy = QUAT_W'(sp_q[2]); e.qz = QUAT_W'(sp_q[3]);
            e.idx = 4'(target);
            e.tol = tol;
            e.done = finished;
            e.disarm = disarm;
            expected_q = {expected_q, e};
        endfunction

        function void check_result(setpoint_t got);
            setpoint_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $time);
                return;
            end
            e = expected_q.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t: exp sp=%0d,%0d,%0d q=%0d,%0d,%0d,%0d",
                        $time, e.x, e.y, e.z, e.qw, e.qx, e.qy, e.qz);
                    $display("    exp idx=%0d tol=%0d done=%0d disarm=%0d",
                        e.idx, e.tol, e.done, e.disarm);
                    $display("    got sp=%0d,%0d,%0d q=%0d,%0d,%0d,%0d",
                        got.x, got.y, got.z, got.qw, got.qx, got.qy, got.qz);
                    $display("    got idx=%0d tol=%0d done=%0d disarm=%0d",
                        got.idx, got.tol, got.done, got.disarm);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    wpas_item_if   item();
    wpas_result_if result();
    wpas_cfg_if    cfg();

    waypoint_arrival_sequencer_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .result(result),
        .cfg   (cfg)
    );

    mission_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && result.valid && result.ready)
            sb.check_result('{result.sp_x, result.sp_y, result.sp_z, result.sp_qw,
                result.sp_qx, result.sp_qy, result.sp_qz, result.target_index,
                result.in_tolerance, result.mission_done, result.disarm_request});

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)
                || (cfg.valid && cfg.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.req_type <= r.kind;
        item.entry_index <= r.entry;
        item.pos_x <= r.px;
        item.pos_y <= r.py;
        item.pos_z <= r.pz;
        item.quat_w <= r.qw;
        item.quat_x <= r.qx;
        item.quat_y <= r.qy;
        item.quat_z <= r.qz;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (STEPS + 10) @(posedge clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [39:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    function automatic request_t make_req(logic [1:0] kind, int e, int x, int y, int z,
                                          int w, int qx, int qy, int qz);
        request_t r;
        r.kind = kind; r.entry = 3'(e);
        r.px = POS_W'(x); r.py = POS_W'(y); r.pz = POS_W'(z);
        r.qw = QUAT_W'(w); r.qx = QUAT_W'(qx); r.qy = QUAT_W'(qy); r.qz = QUAT_W'(qz);
        return r;
    endfunction

    function automatic int rnd_quat();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int rnd_pos();
        return int'($urandom_range(0, 1048575)) - 524288;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int sel, t, pick;
        sel = $urandom_range(0, 99);
        r = make_req(REQ_POSE, $urandom_range(0, 7), rnd_pos(), rnd_pos(), rnd_pos(),
                     rnd_quat(), rnd_quat(), rnd_quat(), rnd_quat());
        if (sel < 4)
            r.kind = REQ_LOAD;
        else if (sel < 7)
            r.kind = REQ_START;
        else if (sel < 9)
            r.kind = REQ_UNUSED;
        else if (sel < 80)
        begin
            t = sb.target < NWP ? sb.target : NWP - 1;
            r.px = POS_W'(sb.wp_x[t] + longint'($urandom_range(0, 16)) - 8);
            r.py = POS_W'(sb.wp_y[t] + longint'($urandom_range(0, 16)) - 8);
            r.pz = POS_W'(sb.wp_z[t] + longint'($urandom_range(0, 16)) - 8);
            r.qw = QUAT_W'(sb.wp_q[t][0]); r.qx = QUAT_W'(sb.wp_q[t][1]);
            r.qy = QUAT_W'(sb.wp_q[t][2]); r.qz = QUAT_W'(sb.wp_q[t][3]);
            if ($urandom_range(0, 9) == 0)
                r.qz = QUAT_W'(sb.wp_q[t][3] + longint'($urandom_range(0, 200)) - 100);
        end
        if (r.kind == REQ_POSE && $urandom_range(0, 3) == 0)
        begin
            pick = $urandom_range(0, 2);
            r.pz = POS_W'(longint'(sb.land) + pick - 1);
        end
        return r;
    endfunction

    initial
    begin
        int unsigned n;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.req_type = REQ_LOAD;
        item.entry_index = '0;
        item.pos_x = '0; item.pos_y = '0; item.pos_z = '0;
        item.quat_w = '0; item.quat_x = '0; item.quat_y = '0; item.quat_z = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_DIST_TOL;
        cfg.data = '0;
        result.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry; odd headings: zero vector, +-pi/2 pre-rotations
        send_request(make_req(REQ_LOAD, 0, 0, 0, 0, 16384, 0, 0, 0));
        send_request(make_req(REQ_LOAD, 1, 524287, 524287, 524287, 0, 0, 8192, 8192));
        send_request(make_req(REQ_LOAD, 2, -524288, -524288, -524288, 0, 0, 0, 16384));
        send_request(make_req(REQ_LOAD, 3, 4096, -4096, 1000, 1000, 0, 0, -16384));
        send_request(make_req(REQ_LOAD, 4, 100, 200, 300, -16384, 16384, -16384, 16384));
        send_request(make_req(REQ_LOAD, 5, -100, 50, 2000, 11585, 0, 0, 11585));
        send_request(make_req(REQ_LOAD, 6, 0, 0, 800, 16384, -16384, 16384, -16384));
        send_request(make_req(REQ_LOAD, 7, 1, -1, 5, 0, 16384, 0, 0));
        send_request(make_req(REQ_UNUSED, 7, -1, -1, -1, -1, -1, -1, -1));
        send_request(make_req(REQ_POSE, 0, 524287, -524288, 524287, 16384, 16384, 16384,
                              16384));
        send_request(make_req(REQ_POSE, 0, 0, 0, 0, 0, 0, 8192, 8192));
        send_request(make_req(REQ_POSE, 0, 0, 0, 0, 16384, 0, 0, 0));
        send_request(make_req(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_POSE, 0, 5, 5, 5, 16384, 0, 0, 0));
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(CFG_DIST_TOL, 40'd0);
                    write_reg(CFG_YAW_TOL, 40'd0);
                    write_reg(CFG_DWELL, 40'd65535);
                    write_reg(CFG_WP_COUNT, 40'd15);
                    write_reg(CFG_LAND, 40'd0);
                end
                2:
                begin
                    write_reg(CFG_DIST_TOL, 40'hFF_FFFF_FFFF);
                    write_reg(CFG_YAW_TOL, 40'd25736);
                    write_reg(CFG_DWELL, 40'd65535);
                    write_reg(CFG_LAND, 40'd524287);
                end
                3:
                begin
                    write_reg(CFG_DIST_TOL, 40'd4000);
                    write_reg(CFG_YAW_TOL, 40'd2000);
                    write_reg(CFG_DWELL, 40'd6);
                    write_reg(CFG_WP_COUNT, 40'd8);
                    write_reg(CFG_LAND, 40'd3000);
                end
                4:
                begin
                    write_reg(CFG_DWELL, 40'd2);
                    write_reg(CFG_WP_COUNT, 40'd0);
                end
                5:
                begin
                    write_reg(CFG_DWELL, 40'd0);
                    write_reg(CFG_LAND, 40'd524287);
                end
                default: ;
            endcase
            cfg.valid <= 1'b0;
            send_idle_pct = (phase % 4 == 1) ? 66 : (phase % 4 == 3) ? 37 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 66 : (phase % 4 == 3) ? 37 : 0;
            for (n = 0; n < 330; n++)
            begin
                if (phase == 2 && n == 150)
                    drain();
                send_request(random_request());
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
